// File: src/rsd_pkg.sv
`timescale 1ns / 1ps

package rsd_pkg;

    localparam int WORD_W   = 32;
    localparam int ADDR_W   = 36;
    localparam int VALUE_W  = 64;
    localparam int SECOND_W = 17;
    localparam int COUNT_W  = 8;
    localparam int DELAY_W  = 26;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Header command types, bits 1:0.
    localparam logic [1:0] TYPE_META    = 2'd0;
    localparam logic [1:0] TYPE_WRITE32 = 2'd1;
    localparam logic [1:0] TYPE_READ    = 2'd2;
    localparam logic [1:0] TYPE_WRITE64 = 2'd3;

    // Meta codes, header bits 5:2.
    localparam logic [3:0] META_END   = 4'd0;
    localparam logic [3:0] META_DELAY = 4'd1;

    typedef enum logic [2:0] {
        KIND_WRITE32   = 3'd0,
        KIND_WRITE64   = 3'd1,
        KIND_READ32    = 3'd2,
        KIND_READ64    = 3'd3,
        KIND_DELAY     = 3'd4,
        KIND_END_OK    = 3'd5,
        KIND_BAD_META  = 3'd6,
        KIND_TRUNCATED = 3'd7
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [ADDR_W-1:0]    address;
        logic [VALUE_W-1:0]   value;
        logic [VALUE_W-1:0]   compare_mask;
        logic                 retry_enable;
        logic [COUNT_W-1:0]   retry_count;
        logic [DELAY_W-1:0]   delay_value;
        logic                 last_of_run;
    } result_t;

endpackage

// File: src/register_sequence_decoder.sv
`timescale 1ns / 1ps

// Each result is queued when its word is accepted. Throughput: one word per
// cycle unless in_stall; a final word that also completes an operation yields
// two items, and the four-entry queue drains them one per cycle unless out_stall.
// Reset (rst_n low, asynchronous) returns the decoder to expecting a header at
// an aligned buffer start and empties the queue; address byte words are not reset.
module register_sequence_decoder
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [rsd_pkg::WORD_W-1:0]        word,
    input  logic                              final_word,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [2:0]                        kind,
    output logic [rsd_pkg::ADDR_W-1:0]        address,
    output logic [rsd_pkg::VALUE_W-1:0]       value,
    output logic [rsd_pkg::VALUE_W-1:0]       compare_mask,
    output logic                              retry_enable,
    output logic [rsd_pkg::COUNT_W-1:0]       retry_count,
    output logic [rsd_pkg::DELAY_W-1:0]       delay_value,
    output logic                              last_of_run
);

    typedef enum logic [3:0] {
        PH_HEADER   = 4'd0,
        PH_ADDR     = 4'd1,
        PH_PAD      = 4'd2,
        PH_W32      = 4'd3,
        PH_W64_LO   = 4'd4,
        PH_W64_HI   = 4'd5,
        PH_RD_SEC   = 4'd6,
        PH_RD_PAD   = 4'd7,
        PH_R32_MASK = 4'd8,
        PH_R32_VAL  = 4'd9,
        PH_R64_ML   = 4'd10,
        PH_R64_MH   = 4'd11,
        PH_R64_VL   = 4'd12,
        PH_R64_VH   = 4'd13
    } phase_t;

    phase_t                          phase_reg, phase_next;
    logic [rsd_pkg::WORD_W-1:0]      header_reg, header_next;
    logic [4:0]                      total_reg, total_next;
    logic [4:0]                      index_reg, index_next;
    logic [rsd_pkg::WORD_W-1:0]      addr_words_reg [4];
    logic [rsd_pkg::SECOND_W-1:0]    second_reg, second_next;
    logic [rsd_pkg::VALUE_W-1:0]     mask_reg, mask_next;
    logic [rsd_pkg::WORD_W-1:0]      low_reg, low_next;
    logic                            odd_reg;
    logic                            done_reg, done_next;

    rsd_pkg::result_t                fifo_reg [rsd_pkg::FIFO_DEPTH];
    logic [rsd_pkg::FIFO_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [rsd_pkg::FIFO_CNT_W-1:0]  count_reg;

    logic                            accept;
    logic                            pop;
    logic                            addr_we;
    logic                            op_valid;
    logic                            trunc_valid;
    rsd_pkg::result_t                op_res;
    rsd_pkg::result_t                trunc_res;
    rsd_pkg::result_t                push0;
    logic [1:0]                      npush;
    logic [4:0]                      index_inc;
    logic [5:0]                      addr_word_count;
    logic [rsd_pkg::WORD_W-1:0]      sel_word;
    logic [7:0]                      sel_byte;
    logic [rsd_pkg::ADDR_W-1:0]      base_addr;
    logic [rsd_pkg::ADDR_W-1:0]      write_addr;
    logic [rsd_pkg::ADDR_W-1:0]      read_addr;
    rsd_pkg::result_t                head;

    // Room for two items is kept so a final word never overflows the queue.
    assign in_stall = (count_reg > rsd_pkg::FIFO_CNT_W'(rsd_pkg::FIFO_DEPTH - 2));
    assign accept   = in_valid && !in_stall;
    assign out_valid = (count_reg != '0);
    assign pop      = out_valid && !out_stall;

    assign index_inc       = index_reg + 5'd1;
    assign addr_word_count = (6'(total_reg) + 6'd3) >> 2;
    assign sel_word   = addr_words_reg[index_reg[3:2]];
    assign sel_byte   = 8'(sel_word >> {index_reg[1:0], 3'b000});
    assign base_addr  = {header_reg[31:6], 10'b0};
    assign write_addr = base_addr | {26'b0, sel_byte, 2'b00};
    assign read_addr  = base_addr | {26'b0, second_reg[7:0], 2'b00};

    always_comb
    begin
        phase_next  = phase_reg;
        header_next = header_reg;
        total_next  = total_reg;
        index_next  = index_reg;
        second_next = second_reg;
        mask_next   = mask_reg;
        low_next    = low_reg;
        done_next   = done_reg;
        addr_we     = 1'b0;
        op_valid    = 1'b0;
        op_res      = '0;

        if (!done_reg)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    header_next = word;
                    if (word[1:0] == rsd_pkg::TYPE_META)
                    begin
                        op_valid = 1'b1;
                        if (word[5:2] == rsd_pkg::META_END)
                        begin
                            op_res.kind = rsd_pkg::KIND_END_OK;
                            done_next   = 1'b1;
                        end
                        else if (word[5:2] == rsd_pkg::META_DELAY)
                        begin
                            op_res.kind        = rsd_pkg::KIND_DELAY;
                            op_res.delay_value = word[31:6];
                        end
                        else
                        begin
                            op_res.kind = rsd_pkg::KIND_BAD_META;
                            done_next   = 1'b1;
                        end
                    end
                    else if (word[1:0] == rsd_pkg::TYPE_READ)
                    begin
                        phase_next = PH_RD_SEC;
                    end
                    else
                    begin
                        total_next = 5'(word[5:2]) + 5'd1;
                        index_next = '0;
                        phase_next = PH_ADDR;
                    end
                end
                PH_ADDR:
                begin
                    addr_we    = 1'b1;
                    index_next = index_inc;
                    if (6'(index_inc) >= addr_word_count)
                    begin
                        index_next = '0;
                        if (header_reg[1:0] == rsd_pkg::TYPE_WRITE32)
                            phase_next = PH_W32;
                        else
                            phase_next = odd_reg ? PH_W64_LO : PH_PAD;
                    end
                end
                PH_PAD:
                begin
                    phase_next = PH_W64_LO;
                end
                PH_W32:
                begin
                    op_valid       = 1'b1;
                    op_res.kind    = rsd_pkg::KIND_WRITE32;
                    op_res.address = write_addr;
                    op_res.value   = {32'b0, word};
                    index_next     = index_inc;
                    if (index_inc >= total_reg)
                        phase_next = PH_HEADER;
                end
                PH_W64_LO:
                begin
                    low_next   = word;
                    phase_next = PH_W64_HI;
                end
                PH_W64_HI:
                begin
                    op_valid       = 1'b1;
                    op_res.kind    = rsd_pkg::KIND_WRITE64;
                    op_res.address = write_addr;
                    op_res.value   = {word, low_reg};
                    index_next     = index_inc;
                    phase_next     = (index_inc >= total_reg) ? PH_HEADER : PH_W64_LO;
                end
                PH_RD_SEC:
                begin
                    second_next = word[rsd_pkg::SECOND_W-1:0];
                    if (header_reg[5])
                        phase_next = odd_reg ? PH_R64_ML : PH_RD_PAD;
                    else
                        phase_next = PH_R32_MASK;
                end
                PH_RD_PAD:
                begin
                    phase_next = PH_R64_ML;
                end
                PH_R32_MASK:
                begin
                    mask_next  = {32'b0, word};
                    phase_next = PH_R32_VAL;
                end
                PH_R32_VAL:
                begin
                    op_valid            = 1'b1;
                    op_res.kind         = rsd_pkg::KIND_READ32;
                    op_res.address      = read_addr;
                    op_res.value        = {32'b0, word};
                    op_res.compare_mask = {32'b0, mask_reg[31:0]};
                    op_res.retry_enable = second_reg[16];
                    op_res.retry_count  = second_reg[15:8];
                    phase_next          = PH_HEADER;
                end
                PH_R64_ML:
                begin
                    low_next   = word;
                    phase_next = PH_R64_MH;
                end
                PH_R64_MH:
                begin
                    mask_next  = {word, low_reg};
                    phase_next = PH_R64_VL;
                end
                PH_R64_VL:
                begin
                    low_next   = word;
                    phase_next = PH_R64_VH;
                end
                PH_R64_VH:
                begin
                    op_valid            = 1'b1;
                    op_res.kind         = rsd_pkg::KIND_READ64;
                    op_res.address      = read_addr;
                    op_res.value        = {word, low_reg};
                    op_res.compare_mask = mask_reg;
                    op_res.retry_enable = second_reg[16];
                    op_res.retry_count  = second_reg[15:8];
                    phase_next          = PH_HEADER;
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase
        end

        // A buffer that ends before End or a bad meta code reports truncation
        // after whatever operation this word completed.
        trunc_valid = final_word && !done_next;
        trunc_res             = '0;
        trunc_res.kind        = rsd_pkg::KIND_TRUNCATED;
        trunc_res.last_of_run = 1'b1;
        op_res.last_of_run    = !trunc_valid;

        push0 = op_valid ? op_res : trunc_res;
        npush = accept ? (2'(op_valid) + 2'(trunc_valid)) : 2'd0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && addr_we)
            addr_words_reg[index_reg[1:0]] <= word;
        if (npush != 2'd0)
            fifo_reg[wr_ptr_reg] <= push0;
        if (npush == 2'd2)
            fifo_reg[wr_ptr_reg + rsd_pkg::FIFO_PTR_W'(1)] <= trunc_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            header_reg <= '0;
            total_reg  <= '0;
            index_reg  <= '0;
            second_reg <= '0;
            mask_reg   <= '0;
            low_reg    <= '0;
            odd_reg    <= 1'b0;
            done_reg   <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                if (final_word)
                begin
                    // The next word opens a new aligned buffer.
                    phase_reg  <= PH_HEADER;
                    header_reg <= '0;
                    total_reg  <= '0;
                    index_reg  <= '0;
                    second_reg <= '0;
                    mask_reg   <= '0;
                    low_reg    <= '0;
                    odd_reg    <= 1'b0;
                    done_reg   <= 1'b0;
                end
                else
                begin
                    phase_reg  <= phase_next;
                    header_reg <= header_next;
                    total_reg  <= total_next;
                    index_reg  <= index_next;
                    second_reg <= second_next;
                    mask_reg   <= mask_next;
                    low_reg    <= low_next;
                    odd_reg    <= !odd_reg;
                    done_reg   <= done_next;
                end
            end
            wr_ptr_reg <= wr_ptr_reg + rsd_pkg::FIFO_PTR_W'(npush);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + rsd_pkg::FIFO_PTR_W'(1);
            count_reg <= count_reg + rsd_pkg::FIFO_CNT_W'(npush)
                         - rsd_pkg::FIFO_CNT_W'(pop);
        end
    end

    assign head         = fifo_reg[rd_ptr_reg];
    assign kind         = head.kind;
    assign address      = head.address;
    assign value        = head.value;
    assign compare_mask = head.compare_mask;
    assign retry_enable = head.retry_enable;
    assign retry_count  = head.retry_count;
    assign delay_value  = head.delay_value;
    assign last_of_run  = head.last_of_run;

endmodule
